// ===== hdl/hds_pkg.sv =====
// hds_pkg: shared constants and types of the heat diffusion stencil unit
// no dependencies; used by hds_row_store, hds_result_fifo and the top level
`default_nettype none

package hds_pkg;

  // default row capacity of the row stores
  localparam int MAX_WIDTH_DEF = 1024;

  // field and register widths
  localparam int VAL_W      = 32;
  localparam int ROW_W      = 16;
  localparam int GW_W       = 11;
  localparam int GH_W       = 16;
  localparam int COEFF_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 4;

  // register reset values
  localparam logic [GW_W-1:0]    GRID_WIDTH_RST  = 11'd1024;
  localparam logic [GH_W-1:0]    GRID_HEIGHT_RST = 16'd1024;
  localparam logic [COEFF_W-1:0] COEFF_RST       = 16'd6554;

  // smallest grid side handled; narrower settings are raised to it
  localparam int MIN_GRID = 3;

  // stencil arithmetic: center weight of four is a shift by two
  localparam int CENTER_WEIGHT_LOG2 = 2;
  localparam int SUM_W  = VAL_W + 4;
  localparam int PROD_W = SUM_W + COEFF_W + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

  // result queue depth (power of two)
  localparam int RESULT_DEPTH = 16;

  // register index, taken from paddr word bits
  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_DIFF_COEFF  = 2'd2
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== hdl/hds_row_store.sv =====
// hds_row_store: the two row stores of the stencil (previous row in two banks, row above)
// depends on hds_pkg
`default_nettype none

module hds_row_store #(
  parameter int MAX_WIDTH = hds_pkg::MAX_WIDTH_DEF
) (
  input  wire                                clk,
  // read of one column: center and its right neighbor of the previous row, and the row above
  input  wire                                rd_en,
  input  wire  [$clog2(MAX_WIDTH)-1:0]       rd_col,
  // previous-row write of the incoming cell
  input  wire                                prior_we,
  input  wire  [$clog2(MAX_WIDTH)-1:0]       prior_col,
  input  wire  [hds_pkg::VAL_W-1:0]          prior_data,
  // row-above write of the retired previous-row cell
  input  wire                                above_we,
  input  wire  [$clog2(MAX_WIDTH)-1:0]       above_col,
  input  wire  [hds_pkg::VAL_W-1:0]          above_data,
  output logic signed [hds_pkg::VAL_W-1:0]   center,
  output logic signed [hds_pkg::VAL_W-1:0]   right,
  output logic signed [hds_pkg::VAL_W-1:0]   up
);

  localparam int HALF  = MAX_WIDTH / 2 + 1;
  localparam int HW    = $clog2(HALF);

  // previous row split into even and odd columns so a column and its right
  // neighbor are read in the same cycle
  logic [hds_pkg::VAL_W-1:0] even_mem  [HALF];
  logic [hds_pkg::VAL_W-1:0] odd_mem   [HALF];
  logic [hds_pkg::VAL_W-1:0] above_mem [MAX_WIDTH];

  logic [hds_pkg::VAL_W-1:0] even_q;
  logic [hds_pkg::VAL_W-1:0] odd_q;
  logic [hds_pkg::VAL_W-1:0] up_q;
  logic                      odd_sel_q;

  logic [HW-1:0] even_rd_addr;
  logic [HW-1:0] odd_rd_addr;
  logic [HW-1:0] prior_wr_addr;

  // odd center reads its right neighbor from the next even entry
  assign even_rd_addr  = HW'(rd_col >> 1) + HW'(rd_col[0]);
  assign odd_rd_addr   = HW'(rd_col >> 1);
  assign prior_wr_addr = HW'(prior_col >> 1);

  // even bank
  always_ff @(posedge clk) begin
    if (prior_we && !prior_col[0]) begin
      even_mem[prior_wr_addr] <= prior_data;
    end
    if (rd_en) begin
      even_q <= even_mem[even_rd_addr];
    end
  end

  // odd bank
  always_ff @(posedge clk) begin
    if (prior_we && prior_col[0]) begin
      odd_mem[prior_wr_addr] <= prior_data;
    end
    if (rd_en) begin
      odd_q <= odd_mem[odd_rd_addr];
    end
  end

  // row above
  always_ff @(posedge clk) begin
    if (above_we) begin
      above_mem[above_col] <= above_data;
    end
    if (rd_en) begin
      up_q <= above_mem[rd_col];
    end
  end

  // bank select follows the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      odd_sel_q <= rd_col[0];
    end
  end

  // steer bank outputs to center and right
  assign center = signed'(odd_sel_q ? odd_q : even_q);
  assign right  = signed'(odd_sel_q ? even_q : odd_q);
  assign up     = signed'(up_q);

endmodule

`default_nettype wire

// ===== hdl/hds_result_fifo.sv =====
// hds_result_fifo: result queue taking up to two results per cycle, draining one
// while out_stall is low; depends on hds_pkg for the default depth
`default_nettype none

module hds_result_fifo #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = hds_pkg::RESULT_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push_a,
  input  wire  [DATA_W-1:0]            data_a,
  input  wire                          push_b,
  input  wire  [DATA_W-1:0]            data_b,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [DATA_W-1:0]            out_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  wr_ptr_b;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count_next;
  logic              pop;

  // second result lands behind the first
  assign wr_ptr_b   = wr_ptr + PTR_W'(push_a);
  assign pop        = out_valid && !out_stall;
  assign count_next = count + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);

  // storage
  always_ff @(posedge clk) begin
    if (push_a) begin
      slots[wr_ptr] <= data_a;
    end
    if (push_b) begin
      slots[wr_ptr_b] <= data_b;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_a) + PTR_W'(push_b);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  // head of queue
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  // pointer distance matches the fill count
  assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[PTR_W-1:0])
    else $error("result queue pointers and count disagree");

  // a result taken at the head leaves the count one lower unless refilled
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push_a && !push_b) |=> count == $past(count) - CNT_W'(1))
    else $error("result queue count did not drop on pop");

endmodule

`default_nettype wire

// ===== hdl/heat_diffusion_5point_stencil_unit.sv =====
// heat_diffusion_5point_stencil_unit: top level of the five-point heat diffusion stencil
// depends on hds_pkg, hds_row_store, hds_result_fifo
//
// Takes one grid cell per cycle, when cell_stall is low, in raster order and gives the diffused grid
// one row late (row 0 at once, the last row also as it arrives). An accepted cell reads
// its center and right neighbor from the two banks of the previous-row store and its upper
// neighbor from the row-above store, forms the neighbor sum, multiplies by alpha and rounds
// and saturates; its results then pass the stage registers into the result queue. Each cell reads
// each store bank once, so the input sustains one cell per cycle; on the last row every cell
// gives two results and the single output port then holds back input. Input stalls when the
// 16-entry result queue cannot take the results of all cells in flight. Row stores need no
// clearing after reset. Configuration registers sit at byte addresses 0 (grid_width),
// 4 (grid_height) and 8 (diffusion_coeff).
`default_nettype none

module heat_diffusion_5point_stencil_unit #(
  parameter int MAX_WIDTH = hds_pkg::MAX_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // configuration port
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [hds_pkg::PADDR_W-1:0]          paddr,
  input  wire  [hds_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [hds_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  // cell input
  input  wire                                  cell_valid,
  output logic                                 cell_stall,
  input  wire  signed [hds_pkg::VAL_W-1:0]     cell_value,
  // result output
  output logic                                 result_valid,
  input  wire                                  result_stall,
  output logic signed [hds_pkg::VAL_W-1:0]     new_value,
  output logic [hds_pkg::ROW_W-1:0]            row_index,
  output logic [$clog2(MAX_WIDTH)-1:0]         col_index,
  output logic                                 frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CW_W  = COL_W + 1;
  localparam int CMP_W = (CW_W > hds_pkg::GW_W) ? CW_W : hds_pkg::GW_W;
  localparam int VAL_W = hds_pkg::VAL_W;
  localparam int ROW_W = hds_pkg::ROW_W;
  localparam int SUM_W = hds_pkg::SUM_W;
  localparam int PROD_W = hds_pkg::PROD_W;
  localparam int ACC_W = hds_pkg::ACC_W;
  localparam int FRAC_W = hds_pkg::FRAC_W;
  localparam int VW    = ACC_W - FRAC_W;
  localparam int DEPTH = hds_pkg::RESULT_DEPTH;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RES_W = CNT_W + 2;
  localparam int DATA_W = VAL_W + ROW_W + COL_W + 1;

  // per-cell control carried down the datapath
  typedef struct packed {
    logic [VAL_W-1:0] x;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] row_a;
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             emit_a;
    logic             emit_b;
    logic             border;
    logic             last_col;
  } cell_meta_t;

  // configuration registers
  logic [hds_pkg::GW_W-1:0]    grid_width;
  logic [hds_pkg::GH_W-1:0]    grid_height;
  logic [hds_pkg::COEFF_W-1:0] diffusion_coeff;
  logic                        cfg_write;

  // position counters
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             wrap_col;
  logic [ROW_W-1:0] row_t;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic             last_col;
  logic             last_row;
  logic             accept;
  cell_meta_t       meta_in;

  // pipeline
  logic              s1_valid, s2_valid, s3_valid;
  cell_meta_t        s1_meta, s2_meta, s3_meta;
  logic signed [VAL_W-1:0]  center, right, up, left;
  logic signed [VAL_W-1:0]  s2_center, s3_center;
  logic signed [SUM_W-1:0]  s2_sum;
  logic signed [PROD_W-1:0] s3_prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [VW-1:0]     v_full;
  logic signed [VAL_W-1:0]  v_sat;
  logic signed [VAL_W-1:0]  a_value;

  // result queue
  logic              push_a, push_b;
  logic [DATA_W-1:0] data_a, data_b, fifo_out;
  logic [CNT_W-1:0]  fifo_count;
  logic [1:0]        inflight;
  logic [RES_W-1:0]  reserved;

  // ---------------------------------------------------------------- config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= hds_pkg::GRID_WIDTH_RST;
      grid_height     <= hds_pkg::GRID_HEIGHT_RST;
      diffusion_coeff <= hds_pkg::COEFF_RST;
    end else if (cfg_write) begin
      case (hds_pkg::reg_idx_t'(paddr[3:2]))
        hds_pkg::REG_GRID_WIDTH:  grid_width      <= pwdata[hds_pkg::GW_W-1:0];
        hds_pkg::REG_GRID_HEIGHT: grid_height     <= pwdata[hds_pkg::GH_W-1:0];
        hds_pkg::REG_DIFF_COEFF:  diffusion_coeff <= pwdata[hds_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (hds_pkg::reg_idx_t'(paddr[3:2]))
      hds_pkg::REG_GRID_WIDTH:  prdata = hds_pkg::APB_DATA_W'(grid_width);
      hds_pkg::REG_GRID_HEIGHT: prdata = hds_pkg::APB_DATA_W'(grid_height);
      hds_pkg::REG_DIFF_COEFF:  prdata = hds_pkg::APB_DATA_W'(diffusion_coeff);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- position
  // effective grid size: width clamped between the minimum and the store, height raised to the minimum
  assign width_ext = CMP_W'(grid_width);
  always_comb begin
    if (width_ext < CMP_W'(hds_pkg::MIN_GRID)) begin
      w_eff = CMP_W'(hds_pkg::MIN_GRID);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (grid_height < ROW_W'(hds_pkg::MIN_GRID)) begin
      h_eff = ROW_W'(hds_pkg::MIN_GRID);
    end else begin
      h_eff = grid_height;
    end
  end

  // normalize the counters against the current size before use
  assign wrap_col = CMP_W'(col_count) >= w_eff;
  assign row_t    = wrap_col ? row_count + ROW_W'(1) : row_count;
  assign cur_row  = (row_t >= h_eff) ? '0 : row_t;
  assign cur_col  = wrap_col ? '0 : col_count;
  assign last_col = CMP_W'(cur_col) == (w_eff - CMP_W'(1));
  assign last_row = cur_row == (h_eff - ROW_W'(1));

  // room for two results of every cell in flight plus the new one
  assign inflight   = 2'(s1_valid) + 2'(s2_valid) + 2'(s3_valid);
  assign reserved   = RES_W'(fifo_count) + (RES_W'(inflight) << 1) + RES_W'(2);
  assign cell_stall = rst || (reserved > RES_W'(DEPTH));
  assign accept     = cell_valid && !cell_stall;

  // counter update
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : cur_row + ROW_W'(1);
      end else begin
        col_count <= cur_col + COL_W'(1);
        row_count <= cur_row;
      end
    end
  end

  // per-cell decisions taken at accept
  always_comb begin
    meta_in.x         = cell_value;
    meta_in.row       = cur_row;
    meta_in.row_a     = (cur_row == '0) ? '0 : cur_row - ROW_W'(1);
    meta_in.col       = cur_col;
    meta_in.first_row = (cur_row == '0);
    meta_in.emit_a    = (cur_row != ROW_W'(1));
    meta_in.emit_b    = last_row;
    meta_in.border    = (cur_col == '0) || last_col;
    meta_in.last_col  = last_col;
  end

  // ---------------------------------------------------------------- row stores
  hds_row_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_row_store (
    .clk        (clk),
    .rd_en      (accept),
    .rd_col     (cur_col),
    .prior_we   (accept),
    .prior_col  (cur_col),
    .prior_data (cell_value),
    .above_we   (s1_valid),
    .above_col  (s1_meta.col),
    .above_data (center),
    .center     (center),
    .right      (right),
    .up         (up)
  );

  // ---------------------------------------------------------------- datapath
  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // stage 1: store data arrives; left neighbor is the previous cell's center
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta_in;
    end
    if (s1_valid) begin
      left      <= center;
      s2_meta   <= s1_meta;
      s2_center <= center;
      // neighbor sum minus four times center
      s2_sum <= SUM_W'(left) + SUM_W'(right) + SUM_W'(up) + SUM_W'(signed'(s1_meta.x))
              - (SUM_W'(center) <<< hds_pkg::CENTER_WEIGHT_LOG2);
    end
  end

  // stage 2: scale by alpha
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_meta   <= s2_meta;
      s3_center <= s2_center;
      s3_prod   <= PROD_W'(s2_sum) * PROD_W'(signed'({1'b0, diffusion_coeff}));
    end
  end

  // stage 3: add center with rounding half, drop fraction, saturate
  assign acc    = ACC_W'(s3_prod) + ACC_W'(signed'({s3_center, hds_pkg::ROUND_HALF}));
  assign v_full = acc[ACC_W-1:FRAC_W];
  always_comb begin
    if ((&v_full[VW-1:VAL_W-1]) || !(|v_full[VW-1:VAL_W-1])) begin
      v_sat = v_full[VAL_W-1:0];
    end else if (v_full[VW-1]) begin
      v_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      v_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // first result: row 0 passes, borders keep center, interior takes the update
  always_comb begin
    if (s3_meta.first_row) begin
      a_value = signed'(s3_meta.x);
    end else if (s3_meta.border) begin
      a_value = s3_center;
    end else begin
      a_value = v_sat;
    end
  end

  assign push_a = s3_valid && s3_meta.emit_a;
  assign push_b = s3_valid && s3_meta.emit_b;
  assign data_a = {a_value, s3_meta.row_a, s3_meta.col, 1'b0};
  assign data_b = {s3_meta.x, s3_meta.row, s3_meta.col, s3_meta.last_col};

  // ---------------------------------------------------------------- result queue
  hds_result_fifo #(
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH)
  ) u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_a    (push_a),
    .data_a    (data_a),
    .push_b    (push_b),
    .data_b    (data_b),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (fifo_out),
    .count     (fifo_count)
  );

  assign {new_value, row_index, col_index, frame_end} = fifo_out;

  // ---------------------------------------------------------------- checks
  // an accepted request enters the datapath next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> s1_valid)
    else $error("accepted cell missing from stage 1");

  // an almost full queue holds off new cells
  assert property (@(posedge clk) disable iff (rst)
    (fifo_count > CNT_W'(DEPTH - 2)) |-> cell_stall)
    else $error("cell taken without queue room");

  // the last column of a row restarts the column count
  assert property (@(posedge clk) disable iff (rst)
    (accept && last_col) |=> col_count == '0)
    else $error("column count did not restart after last column");

endmodule

`default_nettype wire
